// ===== rtl/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the smooth window sieve
// Block geometry, field widths, operation codes, channel payload structs and
// the memory write bundle.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int BLOCK_SIZE = 4096;
  localparam int PRIME_BITS = 28;
  localparam int ADDR_W     = $clog2(BLOCK_SIZE);

  localparam int WORD_W     = 64;
  localparam int HALF_W     = WORD_W / 2;
  localparam int OFFSET_W   = 28;
  localparam int POS_W      = 12;
  localparam int K_W        = 6;
  localparam int RUN_W      = K_W + 1;
  localparam int OP_W       = 2;

  // usable prime bits and width of the walk position (offset plus one step)
  localparam int PB         = (PRIME_BITS < OFFSET_W) ? PRIME_BITS : OFFSET_W;
  localparam int J_W        = OFFSET_W + 1;

  localparam int MAX_DIVS   = 64;
  localparam int NDIV_W     = $clog2(MAX_DIVS) + 1;

  localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
  localparam logic [OP_W-1:0] OP_STRIP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [WORD_W-1:0]   block_base;
    logic [OFFSET_W-1:0] prime;
    logic [WORD_W-1:0]   prime_inverse;
    logic [WORD_W-1:0]   quotient_limit;
    logic [OFFSET_W-1:0] start_offset;
    logic [POS_W-1:0]    position;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] next_offset;
    logic                is_smooth;
    logic                window_hit;
    logic [WORD_W-1:0]   candidate_n;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  // block position of a read, taken modulo the block size
  function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [POS_W-1:0] pos);
    logic [31:0] w;
    w = 32'(pos);
    return w[ADDR_W-1:0];
  endfunction

  // walk step from the prime field, masked to the prime width
  function automatic logic [J_W-1:0] prime_step(input logic [OFFSET_W-1:0] prime);
    return J_W'(prime[PB-1:0]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sws_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/sws_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_mul64: multi-cycle 64 x 64 multiplier, low 64 bits of the product
// One 32 x 32 multiplier is stepped over three partial products and the
// cross terms are folded into the upper half; result holds after done.
// ----------------------------------------------------------------------------
module sws_mul64
  import sws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic                   done,
  output logic      [WORD_W-1:0] result
);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_LL   = 6'b000010,
    M_LH   = 6'b000100,
    M_HL   = 6'b001000,
    M_SUM  = 6'b010000,
    M_DONE = 6'b100000
  } mstate_t;

  mstate_t           state;
  mstate_t           state_next;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: if (start) state_next = M_LL;
      M_LL:   state_next = M_LH;
      M_LH:   state_next = M_HL;
      M_HL:   state_next = M_SUM;
      M_SUM:  state_next = M_DONE;
      M_DONE: state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      M_LH: begin
        mul_x = a_q[HALF_W-1:0];
        mul_y = b_q[WORD_W-1:HALF_W];
      end
      M_HL: begin
        mul_x = a_q[WORD_W-1:HALF_W];
        mul_y = b_q[HALF_W-1:0];
      end
      default: begin
        mul_x = a_q[HALF_W-1:0];
        mul_y = b_q[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE && start) begin
      a_q <= a;
      b_q <= b;
    end
    prod <= WORD_W'(mul_x) * WORD_W'(mul_y);
    case (state)
      M_LH:    acc <= prod;
      M_HL:    acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
      M_SUM:   acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
      default: acc <= acc;
    endcase
  end

  assign done   = (state == M_DONE);
  assign result = acc;

endmodule
`default_nettype wire

// ===== rtl/sws_fill.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_fill: block fill pipeline
// Sweeps every block position, forms base plus position, strips the trailing
// zero bits and writes the odd part to the residue memory, one per cycle.
// ----------------------------------------------------------------------------
module sws_fill
  import sws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] base,
  output ram_wr_t                wr,
  output logic                   done
);

  localparam int NBYTES = WORD_W / 8;
  localparam int SEL_W  = $clog2(NBYTES);

  logic                    busy;
  logic [ADDR_W-1:0]       cnt;
  logic [WORD_W-1:0]       base_q;

  logic                    v1;
  logic [ADDR_W-1:0]       a1;
  logic [WORD_W-1:0]       sum1;

  logic                    v2;
  logic [ADDR_W-1:0]       a2;
  logic [WORD_W-1:0]       val2;
  logic [NBYTES-1:0]       nz2;
  logic [NBYTES-1:0][2:0]  btz2;
  logic [NBYTES-1:0]       nz_c;
  logic [NBYTES-1:0][2:0]  btz_c;

  logic                    v3;
  logic [ADDR_W-1:0]       a3;
  logic [WORD_W-1:0]       data3;
  logic [SEL_W-1:0]        sel_c;
  logic [SEL_W+2:0]        sh_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == ADDR_W'(BLOCK_SIZE - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_q <= base;
    end
  end

  // per byte: any bit set, and lowest set bit
  always_comb begin
    for (int bi = 0; bi < NBYTES; bi++) begin
      nz_c[bi]  = |sum1[bi*8 +: 8];
      btz_c[bi] = 3'd0;
      for (int k = 7; k >= 0; k--) begin
        if (sum1[bi*8 + k]) begin
          btz_c[bi] = 3'(k);
        end
      end
    end
  end

  // lowest nonzero byte picks the shift; zero word shifts by nothing
  always_comb begin
    sel_c = '0;
    for (int bi = NBYTES - 1; bi >= 0; bi--) begin
      if (nz2[bi]) begin
        sel_c = SEL_W'(bi);
      end
    end
    sh_c = {sel_c, btz2[sel_c]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sum1  <= base_q + WORD_W'(cnt);
    a1    <= cnt;
    val2  <= sum1;
    nz2   <= nz_c;
    btz2  <= btz_c;
    a2    <= a1;
    data3 <= val2 >> sh_c;
    a3    <= a2;
  end

  assign wr.en   = v3;
  assign wr.addr = a3;
  assign wr.data = data3;
  assign done    = v3 && (a3 == ADDR_W'(BLOCK_SIZE - 1));

endmodule
`default_nettype wire

// ===== rtl/smooth_window_sieve_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_window_sieve_top: segmented sieve for runs of smooth odd parts
// Residue block in one memory, fill pipeline, strip walker around a
// multi-cycle 64-bit multiplier, and a run counter for reads.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  cfg       in    cfg_we               cfg_wdata (window_k)
//  in        in    in_valid / in_stall  in_data  (in_t)
//  out       out   out_valid / out_stall out_data (out_t)
//
//  read: idle, capture and finish; unused code and zero prime go straight to finish
//  fill: one memory write a cycle through the pipeline
//  strip: per visited entry a read, then one multiply per kept division and
//    one for the failing trial (none once the division cap is hit); each
//    multiply steps the 32x32 multiplier three times
//  in_stall is high while a transaction is being worked; out holds one result
//  synchronous reset clears control; memory contents stay undefined
// ----------------------------------------------------------------------------
module smooth_window_sieve_top
  import sws_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [K_W-1:0] cfg_wdata,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire in_t            in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output out_t                out_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_FILL   = 8'b00000010,
    S_SRD    = 8'b00000100,
    S_SWAIT  = 8'b00001000,
    S_SMUL   = 8'b00010000,
    S_SCHK   = 8'b00100000,
    S_RCAP   = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [K_W-1:0]     window_k;
  logic [WORD_W-1:0]  current_base;
  logic [RUN_W-1:0]   smooth_run;
  logic [RUN_W-1:0]   smooth_run_next;

  logic [J_W-1:0]     p_q;
  logic [WORD_W-1:0]  inv_q;
  logic [WORD_W-1:0]  lim_q;
  logic [J_W-1:0]     j_q;
  logic [WORD_W-1:0]  cur;
  logic [NDIV_W-1:0]  ndiv;
  logic [WORD_W-1:0]  cand;
  out_t               res;

  logic               in_accept;
  logic               out_free;
  logic               j_inside;
  logic               at_max;
  logic               keep_prod;

  logic               fill_start;
  logic               fill_done;
  ram_wr_t            fill_wr;
  ram_wr_t            strip_wr;
  ram_wr_t            ram_wr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               mul_start;
  logic [WORD_W-1:0]  mul_a;
  logic               mul_done;
  logic [WORD_W-1:0]  mul_res;

  logic               rd_smooth;
  logic [RUN_W-1:0]   run_full;
  logic [RUN_W-1:0]   run_inc;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign j_inside  = (j_q < J_W'(BLOCK_SIZE));
  assign at_max    = (ndiv == NDIV_W'(MAX_DIVS));
  // first product always taken, later ones only while within the limit
  assign keep_prod = (ndiv == '0) || (mul_res <= lim_q);

  assign fill_start = in_accept && (in_data.operation == OP_FILL);

  sws_fill u_fill (
    .clk   (clk),
    .rst   (rst),
    .start (fill_start),
    .base  (in_data.block_base),
    .wr    (fill_wr),
    .done  (fill_done)
  );

  assign mul_start = (state == S_SWAIT) || (state == S_SCHK && !at_max);
  assign mul_a     = (state == S_SWAIT) ? ram_rdata : cur;

  sws_mul64 u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (inv_q),
    .done   (mul_done),
    .result (mul_res)
  );

  assign strip_wr.en   = (state == S_SCHK && at_max) ||
                         (state == S_SMUL && mul_done && !keep_prod);
  assign strip_wr.addr = j_q[ADDR_W-1:0];
  assign strip_wr.data = cur;

  assign ram_wr    = (state == S_FILL) ? fill_wr : strip_wr;
  // in idle the read address follows the offered position
  assign ram_raddr = (state == S_IDLE) ? pos_to_addr(in_data.position) : j_q[ADDR_W-1:0];

  sws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLOCK_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // run counter for reads, saturating at window_k + 1
  assign rd_smooth = (ram_rdata[WORD_W-1:1] == '0);
  assign run_full  = RUN_W'(window_k) + 1'b1;
  assign run_inc   = smooth_run + 1'b1;

  always_comb begin
    if (!rd_smooth) begin
      smooth_run_next = '0;
    end else if (run_inc > run_full) begin
      smooth_run_next = run_full;
    end else begin
      smooth_run_next = run_inc;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_data.operation)
            OP_FILL:  state_next = S_FILL;
            OP_STRIP: state_next = (prime_step(in_data.prime) == '0) ? S_FINISH : S_SRD;
            OP_READ:  state_next = S_RCAP;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_FILL:   if (fill_done) state_next = S_FINISH;
      S_SRD:    state_next = j_inside ? S_SWAIT : S_FINISH;
      S_SWAIT:  state_next = S_SMUL;
      S_SMUL: begin
        if (mul_done) begin
          state_next = keep_prod ? S_SCHK : S_SRD;
        end
      end
      S_SCHK:   state_next = at_max ? S_SRD : S_SMUL;
      S_RCAP:   state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_k     <= K_W'(1);
      current_base <= '0;
      smooth_run   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_k <= cfg_wdata;
      end
      if (fill_start) begin
        current_base <= in_data.block_base;
      end
      if (state == S_RCAP) begin
        smooth_run <= smooth_run_next;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_q   <= prime_step(in_data.prime);
      inv_q <= in_data.prime_inverse;
      lim_q <= in_data.quotient_limit;
      j_q   <= J_W'(in_data.start_offset);
      cand  <= current_base + WORD_W'(pos_to_addr(in_data.position));
      res   <= '0;
    end
    if (state == S_SRD && !j_inside) begin
      res.next_offset <= OFFSET_W'(j_q - J_W'(BLOCK_SIZE));
    end
    if (state == S_SWAIT) begin
      ndiv <= '0;
    end
    if (state == S_SMUL && mul_done && keep_prod) begin
      cur  <= mul_res;
      ndiv <= ndiv + 1'b1;
    end
    if (strip_wr.en) begin
      j_q <= j_q + p_q;
    end
    if (state == S_RCAP) begin
      res.is_smooth   <= rd_smooth;
      res.window_hit  <= (smooth_run_next == run_full) && (cand > WORD_W'(window_k));
      res.candidate_n <= cand;
    end
    if (state == S_FINISH && out_free) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_checker: port level checks for the smooth window sieve
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module sws_checker
  import sws_pkg::*;
(
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cfg_we,
  input wire logic [K_W-1:0] cfg_wdata,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire in_t            in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire out_t           out_data
);

  // a held result does not move
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every transaction occupies the block past the accepting edge
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accepting a transaction");

  a_hit_needs_smooth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.window_hit |-> out_data.is_smooth)
    else $error("window hit without a smooth entry");

  // read fields and strip offset never share one result
  a_read_no_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_smooth |-> out_data.next_offset == '0)
    else $error("read result carries an offset");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left the block busy");

endmodule

bind smooth_window_sieve_top sws_checker u_sws_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
